/* rtl/vthc_pkg.sv */
// ----------------------------------------------------------------------------
// vthc_pkg
// Shared types, constants and palette tables of the heat-map colour unit.
// ----------------------------------------------------------------------------
package vthc_pkg;

   // palette geometry
   localparam int INDEX_BITS = 5;
   localparam int PAL_BITS   = 5;
   localparam int PAL_LAST   = 30;
   localparam int PAL_MID    = 15;
   localparam int PAL_SCALE  = 30;

   // floor(y/5) as floor(y*RECIP_FIVE >> RECIP_SHIFT), exact for y below 2**18
   localparam int RECIP_BITS  = 18;
   localparam int RECIP_SHIFT = 18;
   localparam logic [RECIP_BITS-1:0] RECIP_FIVE = 18'd52429;

   // register file
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_RANGE_LOW  = 1'b0;
   localparam logic REG_RANGE_HIGH = 1'b1;

   // colour lanes
   localparam int NUM_CHANNELS = 3;
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_INTERP = 2'd0;
   localparam kind_type KIND_LOW    = 2'd1;
   localparam kind_type KIND_HIGH   = 2'd2;
   localparam kind_type KIND_MID    = 2'd3;

   typedef struct packed {
      logic     valid;
      kind_type kind;
   } tag_type;

   typedef logic [PAL_BITS-1:0]   pal_type;
   typedef logic [INDEX_BITS-1:0] index_type;

   // palette entries in sixteenths
   function automatic pal_type pal_red(input index_type idx);
      pal_type v;
      case (idx) inside
         [5'd0:5'd15]:  v = '0;
         [5'd16:5'd22]: v = pal_type'(idx - 5'd15);
         [5'd23:5'd30]: v = pal_type'(idx - 5'd14);
         default:       v = '0;
      endcase
      return v;
   endfunction

   function automatic pal_type pal_green(input index_type idx);
      pal_type v;
      case (idx) inside
         [5'd0:5'd7]:   v = pal_type'(idx);
         [5'd8:5'd15]:  v = pal_type'(idx + 5'd1);
         [5'd16:5'd22]: v = pal_type'(5'd31 - idx);
         [5'd23:5'd30]: v = pal_type'(5'd30 - idx);
         default:       v = '0;
      endcase
      return v;
   endfunction

   function automatic pal_type pal_blue(input index_type idx);
      pal_type v;
      case (idx) inside
         [5'd0:5'd7]:  v = pal_type'(5'd16 - idx);
         [5'd8:5'd14]: v = pal_type'(5'd15 - idx);
         default:      v = '0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/vthc_prep.sv */
// ----------------------------------------------------------------------------
// vthc_prep
// Range classification and divider set-up: one register stage.
// ----------------------------------------------------------------------------
module vthc_prep import vthc_pkg::*; #(
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic signed [SAMPLE_BITS-1:0]           in_sample,
   input  logic signed [SAMPLE_BITS-1:0]           range_low,
   input  logic signed [SAMPLE_BITS-1:0]           range_high,
   output tag_type                                 out_tag,
   input  logic                                    out_ready,
   output logic [SAMPLE_BITS-1:0]                  out_rem,
   output logic [SAMPLE_BITS-1:0]                  out_den,
   output logic [FRACTION_BITS+INDEX_BITS-1:0]     out_acc
);

   localparam int MW = SAMPLE_BITS + INDEX_BITS;

   logic                          valid_ff;
   kind_type                      kind_ff, kind_in;
   logic [SAMPLE_BITS-1:0]        rem_ff, den_ff, den_in, num;
   logic [FRACTION_BITS+INDEX_BITS-1:0] acc_ff;
   logic [MW-1:0]                 scaled;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      if (range_high == range_low) begin
         kind_in = KIND_MID;
      end else if (in_sample <= range_low) begin
         kind_in = KIND_LOW;
      end else if (in_sample >= range_high) begin
         kind_in = KIND_HIGH;
      end else begin
         kind_in = KIND_INTERP;
      end
   end

   // inside the range 0 < num < den, both fit unsigned
   assign num    = SAMPLE_BITS'(in_sample - range_low);
   assign den_in = SAMPLE_BITS'(range_high - range_low);
   // num * 30 as (num << 5) - (num << 1)
   assign scaled = {num, 5'b0} - {4'b0, num, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         kind_ff <= kind_in;
         den_ff  <= den_in;
         rem_ff  <= scaled[MW-1:INDEX_BITS];
         acc_ff  <= {scaled[INDEX_BITS-1:0], {FRACTION_BITS{1'b0}}};
      end
   end

   assign out_tag = '{valid: valid_ff, kind: kind_ff};
   assign out_rem = rem_ff;
   assign out_den = den_ff;
   assign out_acc = acc_ff;

endmodule

/* rtl/vthc_div_cell.sv */
// ----------------------------------------------------------------------------
// vthc_div_cell
// One restoring-division step: brings in one dividend bit, yields one
// quotient bit, and passes the beat on to the next cell.
// ----------------------------------------------------------------------------
module vthc_div_cell import vthc_pkg::*; #(
   parameter int SAMPLE_BITS = 16,
   parameter int QUOT_BITS   = 13
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tag_type                in_tag,
   output logic                   in_ready,
   input  logic [SAMPLE_BITS-1:0] in_rem,
   input  logic [SAMPLE_BITS-1:0] in_den,
   input  logic [QUOT_BITS-1:0]   in_acc,
   output tag_type                out_tag,
   input  logic                   out_ready,
   output logic [SAMPLE_BITS-1:0] out_rem,
   output logic [SAMPLE_BITS-1:0] out_den,
   output logic [QUOT_BITS-1:0]   out_acc
);

   logic                   valid_ff;
   kind_type               kind_ff;
   logic [SAMPLE_BITS-1:0] rem_ff, rem_in, den_ff;
   logic [QUOT_BITS-1:0]   acc_ff, acc_in;
   logic [SAMPLE_BITS:0]   trial;
   logic [SAMPLE_BITS+1:0] diff;
   logic                   fits;

   assign in_ready = !valid_ff || out_ready;

   // dividend bits leave the top of acc, quotient bits enter at the bottom
   assign trial  = {in_rem, in_acc[QUOT_BITS-1]};
   assign diff   = {1'b0, trial} - {2'b0, in_den};
   assign fits   = !diff[SAMPLE_BITS+1];
   assign rem_in = fits ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
   assign acc_in = {in_acc[QUOT_BITS-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         kind_ff <= in_tag.kind;
         rem_ff  <= rem_in;
         den_ff  <= in_den;
         acc_ff  <= acc_in;
      end
   end

   assign out_tag = '{valid: valid_ff, kind: kind_ff};
   assign out_rem = rem_ff;
   assign out_den = den_ff;
   assign out_acc = acc_ff;

endmodule

/* rtl/vthc_shade.sv */
// ----------------------------------------------------------------------------
// vthc_shade
// Palette blend and 0.8 full-scale channel scaling: three register stages,
// the last of which is the output register.
// ----------------------------------------------------------------------------
module vthc_shade import vthc_pkg::*; #(
   parameter int FRACTION_BITS = 8,
   parameter int CHANNEL_BITS  = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tag_type                             in_tag,
   input  logic [FRACTION_BITS+INDEX_BITS-1:0] in_pos,
   output logic                                in_ready,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [CHANNEL_BITS-1:0]             out_red,
   output logic [CHANNEL_BITS-1:0]             out_green,
   output logic [CHANNEL_BITS-1:0]             out_blue
);

   localparam int QW = FRACTION_BITS + 5;             // blended value, 0..16*2**F
   localparam int SW = FRACTION_BITS + 8;             // signed blend workspace
   localparam int FW = QW + CHANNEL_BITS;             // blended value times full scale
   localparam int YW = CHANNEL_BITS + 2;              // after dropping F+2 bits
   localparam int PW = YW + RECIP_BITS;

   logic valid1_ff, valid2_ff, valid3_ff;
   logic rdy1, rdy2, rdy3;

   index_type               idx_raw, idx_sel;
   logic [FRACTION_BITS-1:0] frac_sel;
   pal_type                 pa [NUM_CHANNELS];
   pal_type                 pb [NUM_CHANNELS];
   logic [QW-1:0]           q_in  [NUM_CHANNELS];
   logic [QW-1:0]           q1_ff [NUM_CHANNELS];
   logic [FW-1:0]           full_prod [NUM_CHANNELS];
   logic [YW-1:0]           y2_ff [NUM_CHANNELS];
   logic [PW-1:0]           recip_prod [NUM_CHANNELS];
   logic [CHANNEL_BITS-1:0] ch3_ff [NUM_CHANNELS];

   function automatic logic [QW-1:0] blend(input pal_type a, input pal_type b,
                                           input logic [FRACTION_BITS-1:0] frac);
      logic signed [5:0]    d;
      logic signed [SW-1:0] base, fr, dd, sum;
      d    = $signed({1'b0, b}) - $signed({1'b0, a});
      base = $signed({3'b0, a, {FRACTION_BITS{1'b0}}});
      fr   = $signed(SW'(frac));
      dd   = {{(SW-6){d[5]}}, d};
      sum  = base + fr * dd;
      return sum[SW-1] ? '0 : sum[QW-1:0];
   endfunction

   function automatic pal_type pal_entry(input int ch, input index_type idx);
      pal_type v;
      case (ch)
         CH_RED:   v = pal_red(idx);
         CH_GREEN: v = pal_green(idx);
         default:  v = pal_blue(idx);
      endcase
      return v;
   endfunction

   assign rdy3     = !valid3_ff || out_ready;
   assign rdy2     = !valid2_ff || rdy3;
   assign rdy1     = !valid1_ff || rdy2;
   assign in_ready = rdy1;

   assign idx_raw = in_pos[FRACTION_BITS+INDEX_BITS-1:FRACTION_BITS];

   // end and middle entries are a blend with zero fraction
   always_comb begin
      idx_sel  = idx_raw;
      frac_sel = in_pos[FRACTION_BITS-1:0];
      case (in_tag.kind)
         KIND_LOW: begin
            idx_sel  = '0;
            frac_sel = '0;
         end
         KIND_HIGH: begin
            idx_sel  = index_type'(PAL_LAST);
            frac_sel = '0;
         end
         KIND_MID: begin
            idx_sel  = index_type'(PAL_MID);
            frac_sel = '0;
         end
         default: begin
            if (idx_raw > index_type'(PAL_LAST - 1)) begin
               idx_sel  = index_type'(PAL_LAST - 1);
               frac_sel = '0;
            end
         end
      endcase
   end

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         pa[c]         = pal_entry(c, idx_sel);
         pb[c]         = pal_entry(c, index_type'(idx_sel + 5'd1));
         q_in[c]       = blend(pa[c], pb[c], frac_sel);
         full_prod[c]  = {q1_ff[c], {CHANNEL_BITS{1'b0}}} - FW'(q1_ff[c]);
         recip_prod[c] = PW'(y2_ff[c]) * PW'(RECIP_FIVE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            valid1_ff <= in_tag.valid;
         end
         if (rdy2) begin
            valid2_ff <= valid1_ff;
         end
         if (rdy3) begin
            valid3_ff <= valid2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (rdy1) begin
            q1_ff[c] <= q_in[c];
         end
         if (rdy2) begin
            y2_ff[c] <= full_prod[c][FRACTION_BITS+YW+1:FRACTION_BITS+2];
         end
         if (rdy3) begin
            ch3_ff[c] <= recip_prod[c][RECIP_SHIFT+CHANNEL_BITS-1:RECIP_SHIFT];
         end
      end
   end

   assign out_valid = valid3_ff;
   assign out_red   = ch3_ff[CH_RED];
   assign out_green = ch3_ff[CH_GREEN];
   assign out_blue  = ch3_ff[CH_BLUE];

endmodule

/* rtl/value_to_heatmap_color_unit.sv */
// ----------------------------------------------------------------------------
// value_to_heatmap_color_unit
// Maps a signed sample onto a 31-entry blue-green-red heat-map palette.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the output is not stalled and returns one
// colour beat per sample, in order. A sample goes through a registered stage
// of range checks and set-up, a chain of FRACTION_BITS + 5 restoring-divider
// cells, one per position bit, that work out (sample - range_low) * 30 /
// (range_high - range_low), and then the palette blending and 0.8 full-scale
// scaling stages that end in the output register.
// Every stage holds its beat only while the stage after it is full and
// stalled, so bubbles close up and the input keeps flowing while a result
// waits. range_low sits at address 0 and range_high at address 4; write them
// only when no sample is in flight.
module value_to_heatmap_color_unit import vthc_pkg::*; #(
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 8,
   parameter int CHANNEL_BITS  = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // req_tdata: sample
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        req_tdata,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // rsp_tdata: red, green, blue
   output logic [((3*CHANNEL_BITS+7)/8)*8-1:0]     rsp_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]                csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]                csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]                csr_prdata,
   output logic                                    csr_pready
);

   localparam int QUOT_BITS = FRACTION_BITS + INDEX_BITS;
   localparam int RSP_BITS  = ((3*CHANNEL_BITS+7)/8)*8;

   logic signed [SAMPLE_BITS-1:0] range_low_ff, range_high_ff;
   logic                          reg_sel;

   tag_type                tag_q [QUOT_BITS+1];
   logic                   rdy_q [QUOT_BITS+1];
   logic [SAMPLE_BITS-1:0] rem_q [QUOT_BITS+1];
   logic [SAMPLE_BITS-1:0] den_q [QUOT_BITS+1];
   logic [QUOT_BITS-1:0]   acc_q [QUOT_BITS+1];

   logic [CHANNEL_BITS-1:0] red, green, blue;

   // register file: word-aligned, low address bits ignored
   assign reg_sel    = csr_paddr[CSR_ADDR_BITS-1];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_sel)
            REG_RANGE_LOW:  range_low_ff  <= csr_pwdata[SAMPLE_BITS-1:0];
            REG_RANGE_HIGH: range_high_ff <= csr_pwdata[SAMPLE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_RANGE_LOW:  csr_prdata = CSR_DATA_BITS'($signed(range_low_ff));
         REG_RANGE_HIGH: csr_prdata = CSR_DATA_BITS'($signed(range_high_ff));
         default:        csr_prdata = '0;
      endcase
   end

   vthc_prep #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_sample  ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .range_low  (range_low_ff),
      .range_high (range_high_ff),
      .out_tag    (tag_q[0]),
      .out_ready  (rdy_q[0]),
      .out_rem    (rem_q[0]),
      .out_den    (den_q[0]),
      .out_acc    (acc_q[0])
   );

   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_cell
      vthc_div_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .QUOT_BITS   (QUOT_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_tag    (tag_q[k]),
         .in_ready  (rdy_q[k]),
         .in_rem    (rem_q[k]),
         .in_den    (den_q[k]),
         .in_acc    (acc_q[k]),
         .out_tag   (tag_q[k+1]),
         .out_ready (rdy_q[k+1]),
         .out_rem   (rem_q[k+1]),
         .out_den   (den_q[k+1]),
         .out_acc   (acc_q[k+1])
      );
   end

   vthc_shade #(
      .FRACTION_BITS (FRACTION_BITS),
      .CHANNEL_BITS  (CHANNEL_BITS)
   ) u_shade (
      .clock     (clock),
      .reset     (reset),
      .in_tag    (tag_q[QUOT_BITS]),
      .in_pos    (acc_q[QUOT_BITS]),
      .in_ready  (rdy_q[QUOT_BITS]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_red   (red),
      .out_green (green),
      .out_blue  (blue)
   );

   assign rsp_tdata = RSP_BITS'({blue, green, red});

endmodule
